>>> rtl/sexpr_token_lexer_unit_macros.svh
// ----------------------------------------------------------------------------
// S-expression lexer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_LEXER_UNIT_MACROS_SVH
`define SEXPR_TOKEN_LEXER_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define STL_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the next cycle.
`define STL_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/stl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-expression lexer package
// Character codes, lexer modes, result kinds and the per-byte result record.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned SymLenW           = 16;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_AFTER  = 3'd4,
    MODE_ERROR  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_END   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  // One result, less the symbol length.
  typedef struct packed {
    kind_t      kind;
    logic       text_valid;
    logic [7:0] text_byte;
    logic       text_first;
    logic       symbol_done;
  } tok_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
           (c == ChFf) || (c == ChCr);
  endfunction

endpackage

>>> rtl/stl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-expression lexer step
// Classify one byte against the current mode; produce the result and the
// next mode and character count.
// ----------------------------------------------------------------------------
module stl_step import stl_pkg::*; #(
  parameter int unsigned CountW = 16
) (
  input  mode_t              mode,
  input  logic [CountW-1:0]  count,
  input  logic [7:0]         c,
  output tok_t               tok,
  output logic [CountW-1:0]  len,
  output mode_t              mode_next,
  output logic [CountW-1:0]  count_next
);

  logic [CountW-1:0] count_inc;
  logic              trailer;
  logic              ends_ok;

  // Saturate at all ones.
  assign count_inc = (&count) ? count : count + CountW'(1);
  assign ends_ok   = is_space(c) || (c == ChClose) || (c == ChNul);

  always_comb begin
    tok        = '{kind: KIND_NONE, text_valid: 1'b0, text_byte: 8'h00,
                   text_first: 1'b0, symbol_done: 1'b0};
    len        = '0;
    mode_next  = mode;
    count_next = count;
    trailer    = 1'b0;

    case (mode)
      MODE_IDENT: begin
        if ((c == ChBslash) || (c == ChOpen) || (c == ChQuote) || (c == ChSemi)) begin
          tok.kind  = KIND_ERROR;
          mode_next = MODE_ERROR;
        end else if (ends_ok) begin
          trailer = 1'b1;
        end else begin
          tok.text_valid = 1'b1;
          tok.text_byte  = c;
          count_next     = count_inc;
        end
      end
      MODE_STRING: begin
        if (c == ChNul) begin
          tok.kind  = KIND_ERROR;
          mode_next = MODE_IDLE;
        end else if (c == ChBslash) begin
          mode_next = MODE_ESCAPE;
        end else begin
          tok.text_valid = 1'b1;
          tok.text_byte  = c;
          count_next     = count_inc;
          if (c == ChQuote) mode_next = MODE_AFTER;
        end
      end
      MODE_ESCAPE: begin
        if (c == ChNul) begin
          tok.kind  = KIND_ERROR;
          mode_next = MODE_IDLE;
        end else begin
          tok.text_valid = 1'b1;
          tok.text_byte  = c;
          count_next     = count_inc;
          mode_next      = MODE_STRING;
        end
      end
      MODE_AFTER: begin
        if (ends_ok) begin
          trailer = 1'b1;
        end else begin
          tok.kind  = KIND_ERROR;
          mode_next = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        if (c == ChNul) begin
          tok.kind  = KIND_END;
          mode_next = MODE_IDLE;
        end else begin
          tok.kind = KIND_ERROR;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        if (c == ChNul) begin
          tok.kind = KIND_END;
        end else if (c == ChOpen) begin
          tok.kind = KIND_OPEN;
        end else if (c == ChClose) begin
          tok.kind = KIND_CLOSE;
        end else if (is_space(c)) begin
          tok.kind = KIND_NONE;
        end else if ((c == ChBslash) || (c == ChSemi)) begin
          tok.kind  = KIND_ERROR;
          mode_next = MODE_ERROR;
        end else begin
          tok.text_valid = 1'b1;
          tok.text_byte  = c;
          tok.text_first = 1'b1;
          count_next     = CountW'(1);
          mode_next      = (c == ChQuote) ? MODE_STRING : MODE_IDENT;
        end
      end
    endcase

    // A valid trailer closes the symbol and may carry a paren or end mark.
    if (trailer) begin
      tok.symbol_done = 1'b1;
      len             = count;
      if (c == ChClose) tok.kind = KIND_CLOSE;
      else if (c == ChNul) tok.kind = KIND_END;
      mode_next  = MODE_IDLE;
      count_next = '0;
    end
  end

endmodule

>>> rtl/sexpr_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-expression token lexer
// Byte-stream lexer: one result per input byte, with symbol text streaming.
// ----------------------------------------------------------------------------
// Feed the stream one byte per request on the in channel; every byte yields
// exactly one result on the out channel. The block sustains one byte per
// cycle while out_ready stays high. A byte taken is held in the input
// register and its result is then registered in the result register (one
// input register, one result register). The rate is set by the loop through
// the lexer mode and character count registers: each byte is classified and
// the mode advanced in one pass. A zero byte marks end of
// stream and returns the lexer to idle, clearing any sticky error. Symbol
// characters come out one per result with text_valid; the byte that ends a
// symbol properly raises symbol_done with the saturating length. The count
// saturates at 2^LENGTH_BITS - 1, capped at 65535.
module sexpr_token_lexer_unit import stl_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   in_byte,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   kind,
  output logic         text_valid,
  output logic [7:0]   text_byte,
  output logic         text_first,
  output logic         symbol_done,
  output logic [15:0]  symbol_length
);

  localparam int unsigned CountW = (LENGTH_BITS < SymLenW) ? LENGTH_BITS : SymLenW;

  // Input register.
  logic              in_full;
  logic [7:0]        byte_q;

  // Lexer state.
  mode_t             mode;
  mode_t             mode_next;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;

  // Result register.
  tok_t              tok;
  tok_t              tok_next;
  logic [CountW-1:0] len;
  logic [CountW-1:0] len_next;

  logic              fire;

  // Process the held byte when the result register is free or draining.
  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  stl_step #(
    .CountW (CountW)
  ) u_step (
    .mode       (mode),
    .count      (count),
    .c          (byte_q),
    .tok        (tok_next),
    .len        (len_next),
    .mode_next  (mode_next),
    .count_next (count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      mode      <= MODE_IDLE;
      count     <= '0;
    end else begin
      // Hold a byte until its result can be registered.
      if (in_ready) in_full <= in_valid;
      if (fire) begin
        out_valid <= 1'b1;
        mode      <= mode_next;
        count     <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) byte_q <= in_byte;
    if (fire) begin
      tok <= tok_next;
      len <= len_next;
    end
  end

  assign kind          = tok.kind;
  assign text_valid    = tok.text_valid;
  assign text_byte     = tok.text_byte;
  assign text_first    = tok.text_first;
  assign symbol_done   = tok.symbol_done;
  assign symbol_length = SymLenW'(len);

  `include "sexpr_token_lexer_unit_macros.svh"

  // A first character is always a text character.
  `STL_CHECK(a_first_is_text, !out_valid || !text_first || text_valid, "text_first without text")
  // A symbol never ends on a byte that also carries text.
  `STL_CHECK(a_done_no_text, !out_valid || !(symbol_done && text_valid), "done with text")
  // Length shows only with symbol_done.
  `STL_CHECK(a_len_only_done, !out_valid || symbol_done || (symbol_length == '0), "stray len")
  // Lexer state moves only when a byte is processed.
  `STL_NEXT(a_state_hold, !fire, $stable(mode) && $stable(count), "state moved idle")
  // A finished symbol always leaves the lexer idle with a cleared count.
  `STL_NEXT(a_done_idle, fire && tok_next.symbol_done, (mode == MODE_IDLE) && (count == '0),
            "not idle after symbol")

endmodule

>>> tb/tb_sexpr_token_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S-expression token lexer testbench
// Feeds byte streams to the lexer through its request handshake and predicts
// each per-byte result with a behavioral lexer of its own. Every result is
// compared field by field with the oldest prediction. Directed streams cover
// whitespace, parens, identifiers, quoted strings with escapes and several error
// paths. Random token streams follow under four idle/stall mixes. A last pass
// drives one long symbol through the length counter.
// ----------------------------------------------------------------------------
module tb_sexpr_token_lexer_unit;
  import stl_pkg::*;

  // Length counter ceiling for the default LENGTH_BITS, held to 16 bits.
  localparam logic [15:0] CountCap = (LengthBitsDefault >= 16) ? 16'hFFFF :
                                     16'((1 << LengthBitsDefault) - 1);
  localparam int unsigned RandomBytesPerPhase = 125;
  localparam int unsigned LongSymbolLen       = 40;
  localparam int unsigned DrainLimit          = 20000;

  // One predicted result for one request byte.
  typedef struct packed {
    kind_t       kind;
    logic        text_valid;
    logic [7:0]  text_byte;
    logic        text_first;
    logic        symbol_done;
    logic [15:0] symbol_length;
  } lex_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic        text_valid;
  logic [7:0]  text_byte;
  logic        text_first;
  logic        symbol_done;
  logic [15:0] symbol_length;

  // Predicted lexer state, advanced once per accepted request.
  mode_t       lex_mode;
  logic [15:0] sym_count;

  // Predictions not yet matched by a result, oldest first.
  lex_result_t pending_results[$];

  // Idle mixes, in percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned bytes_fed       = 0;
  int unsigned results_checked = 0;
  int unsigned symbols_closed  = 0;
  int unsigned error_results   = 0;
  int unsigned end_results     = 0;
  int unsigned mismatch_count  = 0;

  sexpr_token_lexer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .text_valid   (text_valid),
    .text_byte    (text_byte),
    .text_first   (text_first),
    .symbol_done  (symbol_done),
    .symbol_length(symbol_length)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral lexer
  // --------------------------------------------------------------------------

  function automatic logic is_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChLf || c == ChVt ||
           c == ChFf || c == ChCr;
  endfunction

  // Count one more symbol character, holding at the ceiling.
  function automatic void count_char();
    if (sym_count < CountCap) begin
      sym_count++;
    end
  endfunction

  // Advance the predicted state by one byte and return the expected result.
  function automatic lex_result_t lex_predict(input logic [7:0] c);
    lex_result_t r;
    logic        closes_symbol;
    r = '0;
    r.kind = KIND_NONE;
    closes_symbol = 1'b0;
    case (lex_mode)
      MODE_IDENT: begin
        // Identifier body: these bytes end the identifier with an error, not a trailer.
        if (c == ChBslash || c == ChOpen || c == ChQuote || c == ChSemi) begin
          r.kind = KIND_ERROR;
          lex_mode = MODE_ERROR;
        end else if (is_blank(c) || c == ChClose || c == ChNul) begin
          closes_symbol = 1'b1;
        end else begin
          r.text_valid = 1'b1;
          r.text_byte = c;
          count_char();
        end
      end
      MODE_STRING: begin
        if (c == ChNul) begin
          // Stream ended inside a string: flag it and fall back to idle.
          r.kind = KIND_ERROR;
          lex_mode = MODE_IDLE;
        end else if (c == ChBslash) begin
          // Drop the backslash, take the next byte literally.
          lex_mode = MODE_ESCAPE;
        end else begin
          r.text_valid = 1'b1;
          r.text_byte = c;
          count_char();
          if (c == ChQuote) begin
            lex_mode = MODE_AFTER;
          end
        end
      end
      MODE_ESCAPE: begin
        if (c == ChNul) begin
          r.kind = KIND_ERROR;
          lex_mode = MODE_IDLE;
        end else begin
          r.text_valid = 1'b1;
          r.text_byte = c;
          count_char();
          lex_mode = MODE_STRING;
        end
      end
      MODE_AFTER: begin
        // Closing quote must be followed by a proper trailer.
        if (is_blank(c) || c == ChClose || c == ChNul) begin
          closes_symbol = 1'b1;
        end else begin
          r.kind = KIND_ERROR;
          lex_mode = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        // Sticky until end of stream.
        if (c == ChNul) begin
          r.kind = KIND_END;
          lex_mode = MODE_IDLE;
        end else begin
          r.kind = KIND_ERROR;
        end
      end
      default: begin
        lex_mode = MODE_IDLE;
        if (c == ChNul) begin
          r.kind = KIND_END;
        end else if (c == ChOpen) begin
          r.kind = KIND_OPEN;
        end else if (c == ChClose) begin
          r.kind = KIND_CLOSE;
        end else if (is_blank(c)) begin
          r.kind = KIND_NONE;
        end else if (c == ChBslash || c == ChSemi) begin
          r.kind = KIND_ERROR;
          lex_mode = MODE_ERROR;
        end else begin
          r.text_valid = 1'b1;
          r.text_byte = c;
          r.text_first = 1'b1;
          sym_count = '0;
          count_char();
          lex_mode = (c == ChQuote) ? MODE_STRING : MODE_IDENT;
        end
      end
    endcase

    // A proper trailer finishes the symbol; ')' and end keep their own kind.
    if (closes_symbol) begin
      r.symbol_done = 1'b1;
      r.symbol_length = sym_count;
      if (c == ChClose) begin
        r.kind = KIND_CLOSE;
      end else if (c == ChNul) begin
        r.kind = KIND_END;
      end
      lex_mode = MODE_IDLE;
      sym_count = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls plus the scoreboard
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("result %0d: %s mismatch: expected %0d, got %0d",
             results_checked, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_result();
    lex_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request outstanding: kind %0d text_byte %0d",
             kind, text_byte);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", want.kind, kind);
    check_field("text_valid", want.text_valid, text_valid);
    check_field("text_byte", want.text_byte, text_byte);
    check_field("text_first", want.text_first, text_first);
    check_field("symbol_done", want.symbol_done, symbol_done);
    check_field("symbol_length", want.symbol_length, symbol_length);
    results_checked++;
    if (want.symbol_done) begin
      symbols_closed++;
    end
    if (want.kind == KIND_ERROR) begin
      error_results++;
    end
    if (want.kind == KIND_END) begin
      end_results++;
    end
  endfunction

  // Sample the handshake as it stood at the edge, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_result();
    end
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Send one byte: idle for a random stretch, hold valid until accepted, then
  // record the prediction. Valid stays high on return so back-to-back bytes
  // flow without a bubble.
  task automatic send_byte(input logic [7:0] c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= c;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_results.push_back(lex_predict(c));
    bytes_fed++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0: return ChSpace;
      1: return ChTab;
      2: return ChLf;
      3: return ChVt;
      4: return ChFf;
      default: return ChCr;
    endcase
  endfunction

  // Any byte that can sit inside a bare identifier.
  function automatic logic [7:0] ident_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (is_blank(c) || c == ChOpen || c == ChClose || c == ChQuote ||
               c == ChBslash || c == ChSemi);
    return c;
  endfunction

  // Any byte that can sit unescaped inside a string.
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == ChQuote || c == ChBslash);
    return c;
  endfunction

  // Mostly proper trailers; now and then none at all, so the next token
  // collides with the symbol and drives the error path.
  task automatic send_trailer();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_byte(blank_char());
    end else if (pick < 80) begin
      send_byte(ChClose);
    end else if (pick < 90) begin
      send_byte(ChNul);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic apply_reset();
    lex_mode = MODE_IDLE;
    sym_count = '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Whitespace at stream start is skipped; parens need no trailer.
  task automatic test_blanks_and_parens();
    send_byte(ChSpace);
    send_byte(ChTab);
    send_byte(ChLf);
    send_byte(ChVt);
    send_byte(ChFf);
    send_byte(ChCr);
    send_byte(ChOpen);
    send_byte(ChOpen);
    send_byte(ChClose);
  endtask

  // Identifiers closed by whitespace and by ')' in the same result.
  task automatic test_identifiers();
    send_text("ab c");
    send_byte(8'hFF);
    send_byte(ChClose);
  endtask

  // Quoted string with escaped quote and backslash, closed by end of stream.
  task automatic test_quoted_string();
    send_text("\"a\\\"\\\\\"");
    send_byte(ChNul);
  endtask

  // Error paths, each cleared by end of stream.
  task automatic test_error_paths();
    // ';' cannot start an identifier; error is sticky until end.
    send_text(";x");
    send_byte(ChNul);
    // '(' inside an identifier.
    send_text("a(");
    send_byte(ChNul);
    // Backslash cannot start an identifier.
    send_byte(ChBslash);
    send_byte(ChNul);
    // Junk straight after a closing quote.
    send_text("\"\"q");
    send_byte(ChNul);
    // End of stream inside a string, then inside an escape.
    send_byte(ChQuote);
    send_byte(ChNul);
    send_text("\"\\");
    send_byte(ChNul);
  endtask

  // Token-shaped random streams, with some raw noise mixed in.
  task automatic test_random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    start = bytes_fed;
    while (bytes_fed - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 18) begin
        send_byte(ChOpen);
      end else if (pick < 32) begin
        send_byte(ChClose);
      end else if (pick < 46) begin
        send_byte(blank_char());
      end else if (pick < 68) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(ident_char());
        send_trailer();
      end else if (pick < 88) begin
        send_byte(ChQuote);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(4) == 0) begin
            send_byte(ChBslash);
            send_byte(8'($urandom_range(1, 255)));
          end else begin
            send_byte(string_char());
          end
        end
        send_byte(ChQuote);
        send_trailer();
      end else if (pick < 94) begin
        send_byte(ChNul);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // One identifier far longer than the random tokens, closed by a blank.
  task automatic test_long_symbol();
    send_byte(ChNul);
    repeat (LongSymbolLen) send_byte(8'h6B);
    send_byte(ChSpace);
    send_byte(ChNul);
  endtask

  // Drop valid, let every outstanding result arrive, then keep clocking the
  // two-stage pipe to show any stray result.
  task automatic drain_results();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    apply_reset();

    set_idling(0, 0);
    test_blanks_and_parens();
    test_identifiers();
    set_idling(26, 26);
    test_quoted_string();
    test_error_paths();

    set_idling(0, 0);
    test_random_traffic(RandomBytesPerPhase);
    set_idling(55, 0);
    test_random_traffic(RandomBytesPerPhase);
    set_idling(0, 55);
    test_random_traffic(RandomBytesPerPhase);
    set_idling(26, 26);
    test_random_traffic(RandomBytesPerPhase);

    set_idling(0, 0);
    test_long_symbol();

    drain_results();

    $display("Lexed %0d bytes into %0d results under four idle/stall mixes",
             bytes_fed, results_checked);
    $display("Seen %0d finished symbols, %0d error results, %0d end-of-stream marks",
             symbols_closed, error_results, end_results);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
